FILE: src/inode_cache_free_list_core_defines.svh
// assertion macros for the inode cache checker
`ifndef INODE_CACHE_FREE_LIST_CORE_DEFINES_SVH
`define INODE_CACHE_FREE_LIST_CORE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define ICFL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ICFL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: src/icfl_pkg.sv
// shared types and constants for the inode cache free list
`default_nettype none
package icfl_pkg;
    localparam int unsigned ENTRIES_DEF = 64;
    localparam int unsigned SLOT_W = 6;
    localparam int unsigned DEV_W = 8;
    localparam int unsigned INO_W = 32;

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_REMOVE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_WRONG = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t               command;
        logic [SLOT_W-1:0]  slot_index;
        logic [DEV_W-1:0]   device_number;
        logic [INO_W-1:0]   inode_number;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [SLOT_W-1:0]  result_slot;
        logic               slot_was_free;
        logic               list_empty;
    } rsp_t;
endpackage
`default_nettype wire

FILE: src/icfl_ram.sv
// generic single-port ram with registered read
`default_nettype none
module icfl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

FILE: src/icfl_front.sv
// input stage and two-entry request queue
`default_nettype none
module icfl_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire icfl_pkg::req_t in_req,
    output logic               q_valid,
    input  wire logic          q_ready,
    output icfl_pkg::req_t     q_req
);
    import icfl_pkg::*;

    req_t       buf_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = buf_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wp_reg] <= in_req;
        end
    end
endmodule
`default_nettype wire

FILE: src/icfl_back.sv
// sequencer that walks the slot tables and the free list links
`default_nettype none
module icfl_back #(
    parameter int unsigned ENTRIES = icfl_pkg::ENTRIES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    output logic                q_ready,
    input  wire icfl_pkg::req_t q_req,
    output logic                out_valid,
    input  wire logic           out_ready,
    output icfl_pkg::rsp_t      out_rsp
);
    import icfl_pkg::*;

    localparam int unsigned AW = $clog2(ENTRIES);
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    typedef enum logic [10:0] {
        S_INIT   = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_RD     = 11'b00000000100,
        S_DEC    = 11'b00000001000,
        S_ULRD   = 11'b00000010000,
        S_ULW1   = 11'b00000100000,
        S_ULW2   = 11'b00001000000,
        S_APW1   = 11'b00010000000,
        S_APW2   = 11'b00100000000,
        S_SCAN   = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    req_t   req_reg;
    logic [AW-1:0] addr_reg, addr_next;   // init/scan counter
    logic [AW-1:0] slot_reg, slot_next;   // slot being worked on
    logic [AW-1:0] p_reg, p_next, n_reg, n_next;
    logic [AW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic          scan_last_reg, scan_last_next;
    rsp_t          rsp_reg, rsp_next;
    logic          ov_reg, ov_next;
    logic          fr_we, fr_val, fr_rd;
    logic [AW-1:0] fr_addr;

    // link rams: separate ports, address chosen by state
    logic          nx_we, pv_we, tg_we;
    logic [AW-1:0] nx_addr, pv_addr, tg_addr;
    logic [AW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
    logic [DEV_W+INO_W-1:0] tg_wd, tg_rd;

    icfl_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_next (
        .clk(clk), .we(nx_we), .addr(nx_addr), .wdata(nx_wd), .rdata(nx_rd));
    icfl_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_prev (
        .clk(clk), .we(pv_we), .addr(pv_addr), .wdata(pv_wd), .rdata(pv_rd));
    icfl_ram #(.WIDTH(DEV_W+INO_W), .DEPTH(ENTRIES)) u_tag (
        .clk(clk), .we(tg_we), .addr(tg_addr), .wdata(tg_wd), .rdata(tg_rd));
    // free flags, addressed with the tags during a scan
    icfl_ram #(.WIDTH(1), .DEPTH(ENTRIES)) u_free (
        .clk(clk), .we(fr_we), .addr(fr_addr), .wdata(fr_val), .rdata(fr_rd));

    logic slot_ok;
    logic [AW:0] slot_wide;
    assign slot_wide = (AW+1)'(q_req.slot_index);
    assign q_ready   = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_rsp   = rsp_reg;
    assign slot_ok   = (req_reg.slot_index != '0) &&
                       ({{(32-SLOT_W){1'b0}}, req_reg.slot_index} < 32'(ENTRIES));

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        slot_next      = slot_reg;
        p_next         = p_reg;
        n_next         = n_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        scan_last_next = scan_last_reg;
        rsp_next       = rsp_reg;
        ov_next        = ov_reg && !out_ready;
        nx_we = 1'b0; pv_we = 1'b0; tg_we = 1'b0;
        nx_addr = slot_reg; pv_addr = slot_reg; tg_addr = addr_reg;
        nx_wd = '0; pv_wd = '0; tg_wd = '0;
        fr_we = 1'b0; fr_val = 1'b0; fr_addr = slot_reg;
        unique case (state_reg)
            S_INIT:
            begin
                // clearing pass builds the reset links, tags and free flags
                nx_we = 1'b1; pv_we = 1'b1; tg_we = 1'b1;
                nx_addr = addr_reg; pv_addr = addr_reg;
                nx_wd = (addr_reg == LAST) ? '0 : addr_reg + 1'b1;
                pv_wd = (addr_reg == '0) ? LAST : addr_reg - 1'b1;
                fr_we = 1'b1; fr_val = 1'b1; fr_addr = addr_reg;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid && !ov_reg)
                begin
                    state_next = S_DEC;
                    rsp_next = '{status: ST_OK, result_slot: '0,
                                 slot_was_free: 1'b0, list_empty: 1'b0};
                    slot_next = AW'(q_req.slot_index);
                    if (slot_wide >= (AW+1)'(ENTRIES))
                    begin
                        slot_next = '0;
                    end
                    fr_addr = slot_next;
                    if (q_req.command == CMD_LOOKUP)
                    begin
                        addr_next = AW'(1);
                        tg_addr = AW'(1);
                        fr_addr = AW'(1);
                        scan_last_next = (ENTRIES == 2);
                        state_next = S_SCAN;
                    end
                end
            end
            S_DEC:
            begin
                case (req_reg.command)
                    CMD_ALLOC:
                    begin
                        if (head_reg == '0)
                        begin
                            rsp_next.status = ST_EMPTY;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            slot_next = head_reg;
                            nx_addr = head_reg; pv_addr = head_reg;
                            tg_we = 1'b1; tg_addr = head_reg;
                            tg_wd = {req_reg.device_number, req_reg.inode_number};
                            rsp_next.result_slot = SLOT_W'(head_reg);
                            state_next = S_ULRD;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (!slot_ok || !fr_rd)
                        begin
                            rsp_next.status = ST_WRONG;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_ULRD;
                        end
                    end
                    default:
                    begin
                        if (!slot_ok || fr_rd)
                        begin
                            rsp_next.status = ST_WRONG;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            // append at tail
                            nx_we = 1'b1; nx_addr = slot_reg; nx_wd = '0;
                            pv_we = 1'b1; pv_addr = slot_reg; pv_wd = tail_reg;
                            fr_we = 1'b1; fr_val = 1'b1;
                            state_next = S_APW1;
                        end
                    end
                endcase
            end
            S_ULRD:
            begin
                // ram outputs hold prev and next of slot
                p_next = pv_rd;
                n_next = nx_rd;
                state_next = S_ULW1;
            end
            S_ULW1:
            begin
                nx_we = 1'b1; nx_addr = p_reg; nx_wd = n_reg;
                pv_we = 1'b1; pv_addr = n_reg; pv_wd = p_reg;
                if (p_reg == '0) head_next = n_reg;
                if (n_reg == '0) tail_next = p_reg;
                state_next = S_ULW2;
            end
            S_ULW2:
            begin
                nx_we = 1'b1; nx_addr = slot_reg; nx_wd = '0;
                pv_we = 1'b1; pv_addr = slot_reg; pv_wd = '0;
                fr_we = 1'b1; fr_val = 1'b0;
                state_next = S_DONE;
            end
            S_APW1:
            begin
                nx_we = 1'b1; nx_addr = tail_reg; nx_wd = slot_reg;
                pv_we = 1'b1; pv_addr = '0; pv_wd = slot_reg;
                if (tail_reg == '0) head_next = slot_reg;
                tail_next = slot_reg;
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                // tg_rd and fr_rd hold tags and free flag of addr_reg
                tg_addr = addr_reg + 1'b1;
                fr_addr = addr_reg + 1'b1;
                if (tg_rd == {req_reg.device_number, req_reg.inode_number})
                begin
                    rsp_next.result_slot = SLOT_W'(addr_reg);
                    rsp_next.slot_was_free = fr_rd;
                    state_next = S_DONE;
                end
                else if (scan_last_reg)
                begin
                    rsp_next.status = ST_EMPTY;
                    state_next = S_DONE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                    scan_last_next = (addr_reg + 1'b1 == LAST);
                end
            end
            S_DONE:
            begin
                rsp_next.list_empty = (head_reg == '0);
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            addr_reg  <= '0;
            head_reg  <= AW'(1);
            tail_reg  <= LAST;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg      <= slot_next;
        p_reg         <= p_next;
        n_reg         <= n_next;
        scan_last_reg <= scan_last_next;
        rsp_reg       <= rsp_next;
        if (state_reg == S_IDLE && q_valid && !ov_reg)
        begin
            req_reg <= q_req;
        end
    end
endmodule
`default_nettype wire

FILE: src/inode_cache_free_list_core.sv
// top level of the inode cache with free list
// Usage: requests arrive on s_axis (command, slot, device, inode), one result
// per request leaves on m_axis (status, slot, was-free flag, list-empty flag).
// A two-entry request queue decouples the input from the sequencer, so the
// sender can push while the sequencer works or a result waits.
// After reset a clearing pass over all ENTRIES slots writes the reset links, tags
// and free flags; no request is taken from the queue until it is done.
// Allocate takes the head slot and writes its tag; allocate and remove then
// read the slot's links, unlink it and clear its links and free flag; free
// appends the slot at the tail. Rejected requests and allocate on an empty
// list go straight to the result. Lookup scans the tag memory one slot per
// cycle from slot 1 until a hit or the last slot. The link, tag and flag
// memories are single-port. One request is worked on at a time; the next is
// popped the cycle after the result transfer. When m_axis_tready is low the
// result holds in the output register and the sequencer waits; the queue
// keeps accepting until both entries are full.
`default_nettype none
module inode_cache_free_list_core #(
    parameter int unsigned ENTRIES = icfl_pkg::ENTRIES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // command[1:0], slot_index[7:2], device_number[15:8], inode_number[47:16]
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status[1:0], result_slot[7:2], slot_was_free[8], list_empty[9]
    output logic [15:0]      m_axis_tdata
);
    import icfl_pkg::*;

    req_t in_req, q_req;
    rsp_t rsp;
    logic q_valid, q_ready;

    assign in_req.command       = cmd_t'(s_axis_tdata[1:0]);
    assign in_req.slot_index    = s_axis_tdata[7:2];
    assign in_req.device_number = s_axis_tdata[15:8];
    assign in_req.inode_number  = s_axis_tdata[47:16];
    assign m_axis_tdata = {6'd0, rsp.list_empty, rsp.slot_was_free,
                           rsp.result_slot, rsp.status};

    icfl_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(in_req),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req));

    icfl_back #(.ENTRIES(ENTRIES)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_rsp(rsp));
endmodule
`default_nettype wire

FILE: src/icfl_checker.sv
// port-level checker for the inode cache, bound to the top level
`default_nettype none
`include "inode_cache_free_list_core_defines.svh"
module icfl_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);
    `ICFL_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
    `ICFL_ASSERT_IMPL(a_status_code, clk, rst_n, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3, "undefined status")
    `ICFL_ASSERT_IMPL(a_miss_slot, clk, rst_n, m_axis_tvalid && m_axis_tdata[1:0] != 2'd0, m_axis_tdata[7:2] == 6'd0 && !m_axis_tdata[8], "slot reported on failure")
    `ICFL_ASSERT_NEXT(a_one_result, clk, rst_n, m_axis_tvalid && m_axis_tready, !m_axis_tvalid, "results back to back")
endmodule
bind inode_cache_free_list_core icfl_checker u_chk (.*);
`default_nettype wire

FILE: tb/tb_inode_cache_free_list_core.sv
// testbench for the inode cache free list core with its own slot table model
`default_nettype none
module tb_inode_cache_free_list_core;
    import icfl_pkg::*;

    localparam int NSLOT = 64;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        status_t          status;
        logic [5:0]       result_slot;
        logic             slot_was_free;
        logic             list_empty;
    } slot_reply_t;

    // slot table model and queue of predicted replies
    class slot_table_board;
        logic [5:0]  nxt [NSLOT];
        logic [5:0]  prv [NSLOT];
        bit          on_list [NSLOT];
        logic [7:0]  dev_of [NSLOT];
        logic [31:0] ino_of [NSLOT];
        slot_reply_t pending_replies [$];
        int          mismatches;
        int          replies_seen;
        int          cmd_count [4];

        function void clear_table();
            for (int i = 0; i < NSLOT; i++)
            begin
                nxt[i] = (i == NSLOT - 1) ? 6'd0 : 6'(i + 1);
                prv[i] = (i == 0) ? 6'(NSLOT - 1) : 6'(i - 1);
                on_list[i] = 1'b1;
                dev_of[i] = '0;
                ino_of[i] = '0;
            end
        endfunction

        function void take_off(logic [5:0] s);
            logic [5:0] p;
            logic [5:0] n;
            p = prv[s];
            n = nxt[s];
            nxt[p] = n;
            prv[n] = p;
            nxt[s] = '0;
            prv[s] = '0;
            on_list[s] = 1'b0;
        endfunction

        function void note_request(cmd_t c, logic [5:0] s, logic [7:0] d, logic [31:0] ino);
            slot_reply_t r;
            logic [5:0] h;
            r = '{status: ST_OK, result_slot: '0, slot_was_free: 1'b0, list_empty: 1'b0};
            cmd_count[c]++;
            case (c)
                CMD_ALLOC:
                begin
                    if (nxt[0] == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        h = nxt[0];
                        take_off(h);
                        dev_of[h] = d;
                        ino_of[h] = ino;
                        r.result_slot = h;
                    end
                end
                CMD_FREE:
                begin
                    if (s == 0 || on_list[s])
                        r.status = ST_WRONG;
                    else
                    begin
                        h = prv[0];
                        prv[s] = h;
                        nxt[s] = '0;
                        prv[0] = s;
                        nxt[h] = s;
                        on_list[s] = 1'b1;
                    end
                end
                CMD_LOOKUP:
                begin
                    r.status = ST_EMPTY;
                    for (int i = 1; i < NSLOT; i++)
                    begin
                        if (dev_of[i] == d && ino_of[i] == ino)
                        begin
                            r.status = ST_OK;
                            r.result_slot = 6'(i);
                            r.slot_was_free = on_list[i];
                            break;
                        end
                    end
                end
                default:
                begin
                    if (s == 0 || !on_list[s])
                        r.status = ST_WRONG;
                    else
                        take_off(s);
                end
            endcase
            r.list_empty = (nxt[0] == 0);
            pending_replies.push_back(r);
        endfunction

        function void check_reply(logic [15:0] data);
            slot_reply_t exp_r;
            slot_reply_t act;
            act.status = status_t'(data[1:0]);
            act.result_slot = data[7:2];
            act.slot_was_free = data[8];
            act.list_empty = data[9];
            replies_seen++;
            if (pending_replies.size() == 0)
            begin
                $error("reply with nothing expected: %h", data);
                mismatches++;
                return;
            end
            exp_r = pending_replies.pop_front();
            if (act.status != exp_r.status)
            begin
                $error("status expected %0d actual %0d", exp_r.status, act.status);
                mismatches++;
            end
            if (act.result_slot != exp_r.result_slot)
            begin
                $error("result_slot expected %0d actual %0d", exp_r.result_slot,
                       act.result_slot);
                mismatches++;
            end
            if (act.slot_was_free != exp_r.slot_was_free)
            begin
                $error("slot_was_free expected %0d actual %0d", exp_r.slot_was_free,
                       act.slot_was_free);
                mismatches++;
            end
            if (act.list_empty != exp_r.list_empty)
            begin
                $error("list_empty expected %0d actual %0d", exp_r.list_empty,
                       act.list_empty);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // command[1:0], slot_index[7:2], device_number[15:8], inode_number[47:16]
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // status[1:0], result_slot[7:2], slot_was_free[8], list_empty[9]
    logic [15:0] m_axis_tdata;

    inode_cache_free_list_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    slot_table_board board;
    int  send_idle_pct;
    int  sink_stall_pct;
    bit  sink_hold;
    int  quiet_cycles;
    // tag pool keeps lookups hitting often
    logic [7:0]  dev_pool [8];
    logic [31:0] ino_pool [8];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        board = new();
        board.clear_table();
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        send_idle_pct = 0;
        sink_stall_pct = 0;
        sink_hold = 1'b0;
        rst_n = 1'b0;
    end

    // result side: random stall, long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_reply(m_axis_tdata);
            m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("inode_cache_free_list_core test failed");
            $finish;
        end
    end

    // tvalid stays up after a transfer until the next request, an idle gap or a drain
    task automatic send_req(cmd_t c, logic [5:0] s, logic [7:0] d, logic [31:0] ino);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {ino, d, s, c};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_request(c, s, d, ino);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_req();
        int k;
        cmd_t c;
        logic [7:0] d;
        logic [31:0] ino;
        k = $urandom_range(99);
        c = (k < 35) ? CMD_ALLOC : (k < 65) ? CMD_FREE : (k < 85) ? CMD_LOOKUP : CMD_REMOVE;
        if ($urandom_range(9) < 8)
        begin
            d = dev_pool[$urandom_range(7)];
            ino = ino_pool[$urandom_range(7)];
        end
        else
        begin
            d = 8'($urandom);
            ino = $urandom;
        end
        send_req(c, 6'($urandom), d, ino);
    endtask

    initial
    begin
        quiet_cycles = 0;
        for (int i = 0; i < 8; i++)
        begin
            dev_pool[i] = 8'($urandom);
            ino_pool[i] = $urandom;
        end
        dev_pool[0] = 8'hff;
        ino_pool[0] = 32'hffff_ffff;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: sentinel, untouched slots, zero tags, extremes, full drain
        send_req(CMD_LOOKUP, 6'd0, 8'd0, 32'd0);
        send_req(CMD_FREE, 6'd0, 8'd0, 32'd0);
        send_req(CMD_REMOVE, 6'd0, 8'd0, 32'd0);
        send_req(CMD_FREE, 6'd5, 8'd0, 32'd0);
        send_req(CMD_ALLOC, 6'd63, 8'hff, 32'hffff_ffff);
        send_req(CMD_LOOKUP, 6'd0, 8'hff, 32'hffff_ffff);
        send_req(CMD_REMOVE, 6'd1, 8'd0, 32'd0);
        send_req(CMD_REMOVE, 6'd63, 8'd0, 32'd0);
        send_req(CMD_REMOVE, 6'd2, 8'd0, 32'd0);
        send_req(CMD_FREE, 6'd1, 8'd0, 32'd0);
        send_req(CMD_FREE, 6'd63, 8'd0, 32'd0);
        send_req(CMD_LOOKUP, 6'd0, 8'hff, 32'hffff_ffff);
        send_req(CMD_LOOKUP, 6'd0, 8'h12, 32'h3456_789a);
        drain();

        // empty the list, then allocate on empty
        for (int i = 0; i < 64; i++)
            send_req(CMD_ALLOC, 6'($urandom), 8'($urandom), $urandom);
        send_req(CMD_FREE, 6'd17, 8'd0, 32'd0);
        send_req(CMD_ALLOC, 6'd0, 8'd1, 32'd1);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 56 : 29) : 0;
            sink_stall_pct = (ph == 2) ? 56 : (ph == 3) ? 29 : 0;
            if (ph == 0)
            begin
                // long hold-off on results while requests keep coming
                sink_hold = 1'b1;
                fork
                    begin
                        repeat (400) @(posedge clk);
                        sink_hold = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < 300; n++)
                random_req();
            // pause until every reply is back
            drain();
        end

        repeat (100) @(posedge clk);
        $display("covered %0d allocates, %0d frees, %0d lookups, %0d removes; %0d replies",
                 board.cmd_count[0], board.cmd_count[1], board.cmd_count[2],
                 board.cmd_count[3], board.replies_seen);
        if (board.mismatches == 0 && board.pending_replies.size() == 0)
            $display("inode_cache_free_list_core test passed");
        else
            $display("inode_cache_free_list_core test failed");
        $finish;
    end
endmodule
`default_nettype wire

FILE: inode_cache_free_list_core.f
+incdir+src
src/icfl_pkg.sv
src/icfl_ram.sv
src/icfl_front.sv
src/icfl_back.sv
src/inode_cache_free_list_core.sv
src/icfl_checker.sv
tb/tb_inode_cache_free_list_core.sv
